@@ rtl/core/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants, codes and types of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int WORD_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_XOR   = 8'h5E;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    // datapath micro-operations
    typedef logic [2:0] t_uop;
    localparam t_uop UA_NOP        = 3'd0;
    localparam t_uop UA_ACCEPT     = 3'd1;
    localparam t_uop UA_PUSH_DIGIT = 3'd2;
    localparam t_uop UA_POP        = 3'd3;
    localparam t_uop UA_LOAD_X     = 3'd4;
    localparam t_uop UA_LOAD_Y     = 3'd5;
    localparam t_uop UA_EXEC       = 3'd6;
    localparam t_uop UA_PUSH_ACC   = 3'd7;

endpackage

@@ rtl/core/pfe_ifs.sv @@
// ----------------------------------------------------------------------------
// pfe_in_if / pfe_out_if
// Valid/ready channels carrying characters in and results out.
// ----------------------------------------------------------------------------
interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_expr;

    modport source (output valid, output char_code, output end_of_expr, input ready);
    modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface pfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic        [1:0]  status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

@@ rtl/core/pfe_div.sv @@
// ----------------------------------------------------------------------------
// pfe_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating
// toward zero. A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module pfe_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [pfe_pkg::WORD_W-1:0] i_num,
    input  logic signed [pfe_pkg::WORD_W-1:0] i_den,
    output logic                              o_busy,
    output logic        [pfe_pkg::WORD_W-1:0] o_quot
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvd;
    logic [WORD_W-1:0] r_dvs;
    logic              r_neg;
    logic              r_zero;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;
    logic              q_bit;

    assign rem_sh  = {r_rem, r_dvd[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_bit   = ~rem_sub[WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(WORD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvd  <= i_num[WORD_W-1] ? WORD_W'(0) - i_num : i_num;
            r_dvs  <= i_den[WORD_W-1] ? WORD_W'(0) - i_den : i_den;
            r_neg  <= i_num[WORD_W-1] ^ i_den[WORD_W-1];
            r_zero <= (i_den == '0);
        end else if (r_cnt != '0) begin
            r_rem <= q_bit ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            r_dvd <= {r_dvd[WORD_W-2:0], q_bit};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_zero ? '0 : (r_neg ? WORD_W'(0) - r_dvd : r_dvd);

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy) else $error("divider restarted while busy");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy) else $error("divider not busy after start");

endmodule

@@ rtl/core/pfe_dp.sv @@
// ----------------------------------------------------------------------------
// pfe_dp
// Datapath: operand stack memory, operand registers, ALU, error status and
// the output register. Driven one micro-operation per cycle.
// ----------------------------------------------------------------------------
module pfe_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pfe_pkg::t_uop                      i_op,
    input  logic                               i_emit,
    input  logic                               i_in_valid,
    input  logic [7:0]                         i_char_code,
    input  logic                               i_end_of_expr,
    input  logic                               i_out_ready,
    output logic                               o_is_digit,
    output logic                               o_is_op,
    output logic                               o_is_div,
    output logic                               o_is_last,
    output logic                               o_div_busy,
    output logic                               o_out_valid,
    output logic signed [pfe_pkg::WORD_W-1:0]  o_result_value,
    output logic        [1:0]                  o_status
);
    import pfe_pkg::*;

    logic [WORD_W-1:0]  mem [STACK_DEPTH];

    logic [7:0]         r_char;
    logic               r_last;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_err, n_err;
    logic               r_pop_empty;
    logic [WORD_W-1:0]  r_rd_data;
    logic [WORD_W-1:0]  r_x;
    logic [WORD_W-1:0]  r_y;
    logic [WORD_W-1:0]  r_acc;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_value;
    logic [1:0]         r_out_status;

    logic               take;
    logic               full;
    logic               empty;
    logic               push_en;
    logic               pop_en;
    logic [WORD_W-1:0]  push_val;
    logic [WORD_W-1:0]  alu_res;
    logic [WORD_W-1:0]  div_quot;
    logic               div_start;
    logic               err_hit;
    logic [1:0]         err_code;

    assign take  = (i_op == UA_ACCEPT) && i_in_valid && !i_emit;
    assign full  = (r_count == COUNT_W'(STACK_DEPTH));
    assign empty = (r_count == '0);

    assign o_is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign o_is_div   = (r_char == CH_DIV);
    assign o_is_op    = (r_char == CH_PLUS) || (r_char == CH_MINUS) ||
                        (r_char == CH_MUL) || (r_char == CH_DIV) || (r_char == CH_XOR);
    assign o_is_last  = r_last;

    assign div_start = (i_op == UA_EXEC) && !i_emit && o_is_div;

    pfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_y),
        .i_den   (r_x),
        .o_busy  (o_div_busy),
        .o_quot  (div_quot)
    );

    always_comb begin
        case (r_char)
            CH_PLUS:  alu_res = r_y + r_x;
            CH_MINUS: alu_res = r_y - r_x;
            CH_MUL:   alu_res = r_y * r_x;
            default:  alu_res = r_y ^ r_x;
        endcase
    end

    always_comb begin
        push_en  = 1'b0;
        pop_en   = 1'b0;
        push_val = o_is_div ? div_quot : r_acc;
        err_hit  = 1'b0;
        err_code = ST_OK;
        if (!i_emit) begin
            unique case (i_op)
                UA_PUSH_DIGIT: begin
                    push_en  = 1'b1;
                    push_val = {{(WORD_W-4){1'b0}}, r_char[3:0]};
                end
                UA_PUSH_ACC: push_en = 1'b1;
                UA_POP:      pop_en  = 1'b1;
                UA_EXEC: begin
                    err_hit  = o_is_div && (r_x == '0);
                    err_code = ST_DIVZERO;
                end
                default: ;
            endcase
        end
        if (push_en && full) begin
            err_hit  = 1'b1;
            err_code = ST_OVERFLOW;
        end
        if (pop_en && empty) begin
            err_hit  = 1'b1;
            err_code = ST_UNDERFLOW;
        end
    end

    always_comb begin
        n_count = r_count;
        n_err   = r_err;
        if (i_emit) begin
            n_count = '0;
            n_err   = ST_OK;
        end else begin
            if (push_en && !full)
                n_count = r_count + 1'b1;
            if (pop_en && !empty)
                n_count = r_count - 1'b1;
            if (err_hit && r_err == ST_OK)
                n_err = err_code;
        end
    end

    // stack storage, registered read
    always_ff @(posedge i_clk) begin
        if (push_en && !full)
            mem[ADDR_W'(r_count)] <= push_val;
        if (pop_en && !empty)
            r_rd_data <= mem[ADDR_W'(r_count - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (i_emit)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= i_char_code;
            r_last <= i_end_of_expr;
        end
        if (pop_en)
            r_pop_empty <= empty;
        if (i_op == UA_LOAD_X && !i_emit)
            r_x <= r_pop_empty ? '0 : r_rd_data;
        if (i_op == UA_LOAD_Y && !i_emit)
            r_y <= r_pop_empty ? '0 : r_rd_data;
        if (i_op == UA_EXEC && !i_emit)
            r_acc <= alu_res;
        if (i_emit) begin
            r_out_value  <= r_x;
            r_out_status <= r_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(STACK_DEPTH)) else $error("stack count out of range");
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit |=> (r_count == '0) && (r_err == ST_OK) && r_out_valid)
        else $error("emit did not clear the stack");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && !i_emit) |=> r_err == $past(r_err))
        else $error("first error overwritten");

endmodule

@@ rtl/core/pfe_seq.sv @@
// ----------------------------------------------------------------------------
// pfe_seq
// Microcode sequencer: a 16-step program in a constant table, one control
// word per step, with a step counter and conditional jumps.
// ----------------------------------------------------------------------------
module pfe_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_is_digit,
    input  logic          i_is_op,
    input  logic          i_is_div,
    input  logic          i_is_last,
    input  logic          i_div_busy,
    input  logic          i_out_full,
    output pfe_pkg::t_uop o_op,
    output logic          o_emit
);
    import pfe_pkg::*;

    localparam int UPC_W = 4;

    typedef logic [3:0] t_cond;
    localparam t_cond C_NEXT      = 4'd0;
    localparam t_cond C_ALWAYS    = 4'd1;
    localparam t_cond C_NOT_VALID = 4'd2;
    localparam t_cond C_NOT_DIGIT = 4'd3;
    localparam t_cond C_NOT_OP    = 4'd4;
    localparam t_cond C_NOT_DIV   = 4'd5;
    localparam t_cond C_DIV_BUSY  = 4'd6;
    localparam t_cond C_NOT_LAST  = 4'd7;
    localparam t_cond C_OUT_FULL  = 4'd8;

    typedef struct packed {
        t_uop             op;
        logic             emit;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{op: UA_NOP, emit: 1'b0, cond: C_NEXT, target: '0};
        unique case (addr)
            4'd0:  w = '{UA_ACCEPT,     1'b0, C_NOT_VALID, 4'd0};
            4'd1:  w = '{UA_NOP,        1'b0, C_NOT_DIGIT, 4'd3};
            4'd2:  w = '{UA_PUSH_DIGIT, 1'b0, C_ALWAYS,    4'd11};
            4'd3:  w = '{UA_NOP,        1'b0, C_NOT_OP,    4'd11};
            4'd4:  w = '{UA_POP,        1'b0, C_NEXT,      4'd0};
            4'd5:  w = '{UA_LOAD_X,     1'b0, C_NEXT,      4'd0};
            4'd6:  w = '{UA_POP,        1'b0, C_NEXT,      4'd0};
            4'd7:  w = '{UA_LOAD_Y,     1'b0, C_NEXT,      4'd0};
            4'd8:  w = '{UA_EXEC,       1'b0, C_NOT_DIV,   4'd10};
            4'd9:  w = '{UA_NOP,        1'b0, C_DIV_BUSY,  4'd9};
            4'd10: w = '{UA_PUSH_ACC,   1'b0, C_NEXT,      4'd0};
            4'd11: w = '{UA_NOP,        1'b0, C_NOT_LAST,  4'd0};
            4'd12: w = '{UA_POP,        1'b0, C_NEXT,      4'd0};
            4'd13: w = '{UA_LOAD_X,     1'b0, C_NEXT,      4'd0};
            4'd14: w = '{UA_NOP,        1'b0, C_OUT_FULL,  4'd14};
            4'd15: w = '{UA_NOP,        1'b1, C_ALWAYS,    4'd0};
            default: ;
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] r_upc, n_upc;
    t_uword           uw;
    logic             jump;

    assign uw = ucode_rom(r_upc);

    always_comb begin
        case (uw.cond)
            C_ALWAYS:    jump = 1'b1;
            C_NOT_VALID: jump = !i_in_valid;
            C_NOT_DIGIT: jump = !i_is_digit;
            C_NOT_OP:    jump = !i_is_op;
            C_NOT_DIV:   jump = !i_is_div;
            C_DIV_BUSY:  jump = i_div_busy;
            C_NOT_LAST:  jump = !i_is_last;
            C_OUT_FULL:  jump = i_out_full;
            default:     jump = 1'b0;
        endcase
        n_upc = jump ? uw.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= '0;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_op   = uw.op;
    assign o_emit = uw.emit;

endmodule

@@ rtl/core/postfix_expression_evaluator.sv @@
// Steps: a digit runs steps 0, 1, 2 and 11; a +, -, * or ^ runs 0, 1, 3 to
// 8, 10 and 11; a / also waits in step 9 while the divider is busy; any
// other character runs 0, 1, 3 and 11. The marked last character then runs
// 12 to 15, waiting in 14 for the earlier result to leave; 15 loads the result.
// Throughput: one character at a time; the next is taken on return to step 0.
// Reset (synchronous, active low) empties the stack and clears status and
// output valid; stack words are not cleared.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix expressions over a stack of signed 32-bit words, one
// character per transaction, under a microcoded sequencer.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfe_in_if.sink     i_in,
    pfe_out_if.source  o_out
);
    import pfe_pkg::*;

    t_uop op;
    logic emit;
    logic is_digit;
    logic is_op;
    logic is_div;
    logic is_last;
    logic div_busy;
    logic out_valid;

    pfe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_is_digit (is_digit),
        .i_is_op    (is_op),
        .i_is_div   (is_div),
        .i_is_last  (is_last),
        .i_div_busy (div_busy),
        .i_out_full (out_valid),
        .o_op       (op),
        .o_emit     (emit)
    );

    pfe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_emit         (emit),
        .i_in_valid     (i_in.valid),
        .i_char_code    (i_in.char_code),
        .i_end_of_expr  (i_in.end_of_expr),
        .i_out_ready    (o_out.ready),
        .o_is_digit     (is_digit),
        .o_is_op        (is_op),
        .o_is_div       (is_div),
        .o_is_last      (is_last),
        .o_div_busy     (div_busy),
        .o_out_valid    (out_valid),
        .o_result_value (o_out.result_value),
        .o_status       (o_out.status)
    );

    assign i_in.ready  = (op == UA_ACCEPT) && !emit;
    assign o_out.valid = out_valid;

endmodule
